@@ rtl/atw_pkg.sv @@
// ----------------------------------------------------------------------------
// atw_pkg - shared constants, types and tanh table for the waveshaper
// Widths follow from SAMPLE_BITS and TANH_SEGMENTS. The tanh table is built
// once at elaboration.
// ----------------------------------------------------------------------------
package atw_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int TANH_SEGMENTS = 256;  // power of two
  localparam int SEG_BITS      = $clog2(TANH_SEGMENTS);
  localparam int FRAC_BITS     = SAMPLE_BITS - 1;

  // configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 17;
  localparam int GAIN_BITS     = 16;
  localparam int OGAIN_BITS    = 14;
  localparam int ASYM_BITS     = 16;
  localparam int WET_BITS      = 17;

  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE      = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_DRIVE_GAIN  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_INPUT_GAIN  = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_OUTPUT_GAIN = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] REG_ASYMMETRY   = CFG_IDX_BITS'(4);
  localparam logic [CFG_IDX_BITS-1:0] REG_WET_MIX     = CFG_IDX_BITS'(5);

  localparam int GAIN_ONE = 4096;   // 1.0 in Q4.12
  localparam int WET_ONE  = 65536;  // 1.0 in Q1.16

  // combined gain, Q8.12
  localparam int G_PROD_BITS = 2 * GAIN_BITS;
  localparam int G_SHIFT     = 12;
  localparam int G_BITS      = G_PROD_BITS - G_SHIFT;
  localparam int G_ROUND     = 1 << (G_SHIFT - 1);

  // driven magnitude, aligned to 32 fraction bits
  localparam int A_SHIFT     = FRAC_BITS + G_SHIFT - 32;
  localparam int A_RSH       = (A_SHIFT > 0) ? A_SHIFT : 0;
  localparam int A_LSH       = (A_SHIFT < 0) ? -A_SHIFT : 0;
  localparam int PROD_A_BITS = SAMPLE_BITS + G_BITS;
  localparam int A_WIDE      = PROD_A_BITS + A_LSH;
  localparam int A_BITS      = A_WIDE - A_RSH;

  // asymmetry scale, Q1.16
  localparam int SCALE_BITS    = 17;
  localparam int SCALE_ONE     = 1 << 16;
  localparam int ARG_PROD_BITS = A_BITS + SCALE_BITS;
  localparam int ARG_BITS      = ARG_PROD_BITS - 16;

  // table span is 8.0 in Q.32
  localparam int SPAN_BIT = 35;
  localparam int IDX_LSB  = SPAN_BIT - SEG_BITS;
  localparam int FR_BITS  = 16;
  localparam int FR_LSB   = IDX_LSB - FR_BITS;

  localparam int ROM_BITS   = 32;
  localparam int IP_BITS    = ROM_BITS + FR_BITS + 1;
  localparam int IP_ROUND   = 1 << (FR_BITS - 1);
  localparam int ROUND_SH   = 31 - FRAC_BITS;
  localparam int ROUND_HALF = (1 << ROUND_SH) >> 1;

  // wet/dry mix and output gain
  localparam int MIX_BITS  = SAMPLE_BITS + WET_BITS + 2;
  localparam int V_BITS    = MIX_BITS + 1;
  localparam int VG_BITS   = V_BITS + OGAIN_BITS + 1;
  localparam int OUT_SHIFT = 28;
  localparam int RQ_BITS   = VG_BITS + 1 - OUT_SHIFT;

  typedef logic [TANH_SEGMENTS:0][ROM_BITS-1:0] tanh_rom_t;

  typedef struct packed {
    logic [ROM_BITS-1:0] lo;    // lower table entry
    logic [ROM_BITS-1:0] diff;  // upper minus lower
    logic                ge;    // upper >= lower, interpolate
  } tanh_seg_t;

  // shift-subtract quotient, elaboration only
  function automatic longint unsigned udiv_u64(longint unsigned num,
                                               longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh(8k/N) in Q0.31: series for e^(-k/N), squared four times,
  // then (1-y)/(1+y) with rounding
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t       rom;
    longint unsigned q30;
    longint unsigned w;
    longint unsigned term;
    longint unsigned y;
    longint unsigned kk;
    longint          sum;
    q30 = 64'd1 << 30;
    for (int k = 0; k <= TANH_SEGMENTS; k++) begin
      kk   = longint'(k);
      w    = (kk << 30) >> SEG_BITS;
      sum  = longint'(q30);
      term = q30;
      for (int i = 1; i <= 14; i++) begin
        term = udiv_u64((term * w) >> 30, 64'(i));
        if (i[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      y = longint'(sum);
      if (y > q30) begin
        y = q30;
      end
      for (int r = 0; r < 4; r++) begin
        y = (y * y + (64'd1 << 29)) >> 30;
      end
      rom[k] = ROM_BITS'(udiv_u64(((q30 - y) << 31) + ((q30 + y) >> 1), q30 + y));
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

@@ rtl/atw_tanh_lut.sv @@
// ----------------------------------------------------------------------------
// atw_tanh_lut - tanh table segment lookup
// Returns the lower entry and the slope of one table segment; at or past
// the end of the span the last entry with zero slope.
// ----------------------------------------------------------------------------
module atw_tanh_lut (
  input  logic                        span_sat,
  input  logic [atw_pkg::SEG_BITS-1:0] seg_idx,
  output atw_pkg::tanh_seg_t          seg
);
  import atw_pkg::*;

  logic [SEG_BITS:0]   idx_lo;
  logic [SEG_BITS:0]   idx_hi;
  logic [ROM_BITS-1:0] lo;
  logic [ROM_BITS-1:0] hi;

  always_comb begin
    idx_lo = {1'b0, seg_idx};
    idx_hi = idx_lo + (SEG_BITS + 1)'(1);
    lo     = TANH_ROM[idx_lo];
    hi     = TANH_ROM[idx_hi];
    if (span_sat) begin
      seg.lo   = TANH_ROM[TANH_SEGMENTS];
      seg.diff = '0;
      seg.ge   = 1'b0;
    end else begin
      seg.lo   = lo;
      seg.diff = hi - lo;
      seg.ge   = (hi >= lo);
    end
  end

endmodule

@@ rtl/asymmetric_tanh_waveshaper.sv @@
// ----------------------------------------------------------------------------
// asymmetric_tanh_waveshaper - asymmetric tanh distortion, one sample a clock unless stalled
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in_     | request   | in_valid / in_stall   | in_sample_in, in_block_end
//   out_    | result    | out_valid / out_stall | out_sample_out, out_block_end_out
//   cfg_    | write     | cfg_we                | cfg_index, cfg_data
//
// Nine register stages, the last one the output register. A sample enters
// every clock while the output does not stall; the widest multiply is the
// mix sum x output gain in s8.
// Each stage carries its own valid bit and loads when empty or when the next
// stage moves, so a stalled output only stops what sits behind it.
// Synchronous active-low reset clears the valid bits and loads the defaults.
// ----------------------------------------------------------------------------
module asymmetric_tanh_waveshaper (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // request channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [atw_pkg::SAMPLE_BITS-1:0] in_sample_in,
  input  logic                                   in_block_end,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [atw_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic                                   out_block_end_out,
  // configuration writes
  input  logic                                   cfg_we,
  input  logic [atw_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [atw_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import atw_pkg::*;

  localparam int STAGES = 9;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic                  enable_r;
  logic [GAIN_BITS-1:0]  drive_r;
  logic [GAIN_BITS-1:0]  igain_r;
  logic [OGAIN_BITS-1:0] ogain_r;
  logic [ASYM_BITS-1:0]  asym_r;
  logic [WET_BITS-1:0]   wet_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      drive_r  <= GAIN_BITS'(GAIN_ONE);
      igain_r  <= GAIN_BITS'(GAIN_ONE);
      ogain_r  <= OGAIN_BITS'(GAIN_ONE);
      asym_r   <= '0;
      wet_r    <= WET_BITS'(WET_ONE);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:      enable_r <= cfg_data[0];
        REG_DRIVE_GAIN:  drive_r  <= cfg_data[GAIN_BITS-1:0];
        REG_INPUT_GAIN:  igain_r  <= cfg_data[GAIN_BITS-1:0];
        REG_OUTPUT_GAIN: ogain_r  <= cfg_data[OGAIN_BITS-1:0];
        REG_ASYMMETRY:   asym_r   <= cfg_data[ASYM_BITS-1:0];
        REG_WET_MIX:     wet_r    <= cfg_data[WET_BITS-1:0];
        default: ;  // unused index, dropped
      endcase
    end
  end

  // Derived coefficients, recomputed every clock. Config must only move while
  // idle; the block does not enforce this. s2 reads them first, after the intake register.
  logic [G_PROD_BITS-1:0] g_prod;
  logic [G_BITS-1:0]      g_r;
  logic [WET_BITS-1:0]    wet_w_nxt;
  logic [WET_BITS-1:0]    wet_w_r;
  logic [WET_BITS-1:0]    dry_w_r;

  always_comb begin
    g_prod    = G_PROD_BITS'(igain_r) * G_PROD_BITS'(drive_r) + G_PROD_BITS'(G_ROUND);
    wet_w_nxt = (wet_r > WET_BITS'(WET_ONE)) ? WET_BITS'(WET_ONE) : wet_r;
  end

  always_ff @(posedge clk) begin
    g_r     <= g_prod[G_PROD_BITS-1:G_SHIFT];
    wet_w_r <= wet_w_nxt;
    dry_w_r <= WET_BITS'(WET_ONE) - wet_w_nxt;
  end

  // --------------------------------------------------------------------------
  // stage flow control
  // --------------------------------------------------------------------------
  logic [STAGES:1]   v_r;
  logic [STAGES:1]   v_nxt;
  logic [STAGES:1]   v_src;
  logic [STAGES+1:1] en;
  logic              in_acc;
  logic              out_acc;

  always_comb begin
    en[STAGES+1] = !out_stall;
    for (int k = STAGES; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_src = {v_r[STAGES-1:1], in_valid};
    v_nxt = (en[STAGES:1] & v_src) | (~en[STAGES:1] & v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = v_r[STAGES];
  assign in_acc    = in_valid && en[1];
  assign out_acc   = out_valid && !out_stall;

  // --------------------------------------------------------------------------
  // datapath
  // --------------------------------------------------------------------------
  // s1: intake
  logic signed [SAMPLE_BITS-1:0] x1_r;
  logic                          be1_r;
  // s2: |x| * input gain * drive
  logic [SAMPLE_BITS-1:0]        m_abs;
  logic [PROD_A_BITS-1:0]        prod_a;
  logic [A_WIDE-1:0]             a_wide;
  logic [A_BITS-1:0]             a_nxt;
  logic [A_BITS-1:0]             a2_r;
  logic                          neg2_r;
  logic signed [SAMPLE_BITS-1:0] x2_r;
  logic                          be2_r;
  // s3: asymmetry scale, split tanh argument
  logic [SCALE_BITS-1:0]         scale;
  logic [ARG_PROD_BITS-1:0]      arg_prod;
  logic [ARG_BITS-1:0]           arg;
  logic                          sat3_r;
  logic [SEG_BITS-1:0]           idx3_r;
  logic [FR_BITS-1:0]            fr3_r;
  logic                          neg3_r;
  logic signed [SAMPLE_BITS-1:0] x3_r;
  logic                          be3_r;
  // s4: table segment
  tanh_seg_t                     seg;
  tanh_seg_t                     seg4_r;
  logic [FR_BITS-1:0]            fr4_r;
  logic                          neg4_r;
  logic signed [SAMPLE_BITS-1:0] x4_r;
  logic                          be4_r;
  // s5: interpolation
  logic [IP_BITS-1:0]            ip;
  logic [ROM_BITS-1:0]           val_nxt;
  logic [ROM_BITS-1:0]           val5_r;
  logic                          neg5_r;
  logic signed [SAMPLE_BITS-1:0] x5_r;
  logic                          be5_r;
  // s6: wet and dry products
  logic [ROM_BITS:0]             mag_sum;
  logic [SAMPLE_BITS-1:0]        mag;
  logic signed [SAMPLE_BITS:0]   shaped;
  logic signed [WET_BITS:0]      wet_s;
  logic signed [WET_BITS:0]      dry_s;
  logic signed [MIX_BITS-1:0]    p1_6_r;
  logic signed [MIX_BITS-1:0]    p2_6_r;
  logic signed [SAMPLE_BITS-1:0] x6_r;
  logic                          be6_r;
  // s7: mix sum
  logic signed [V_BITS-1:0]      v7_r;
  logic signed [SAMPLE_BITS-1:0] x7_r;
  logic                          be7_r;
  // s8: output gain
  logic signed [OGAIN_BITS:0]    og_s;
  logic signed [VG_BITS-1:0]     vg8_r;
  logic signed [SAMPLE_BITS-1:0] x8_r;
  logic                          be8_r;
  // s9: round, saturate, select bypass
  logic                          vg_neg;
  logic [VG_BITS-1:0]            vm;
  logic [VG_BITS:0]              vm_sum;
  logic [RQ_BITS-1:0]            rq;
  logic [SAMPLE_BITS-1:0]        res_mag;
  logic signed [SAMPLE_BITS-1:0] shaped_out;
  logic signed [SAMPLE_BITS-1:0] out_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_be_r;

  atw_tanh_lut u_lut (
    .span_sat (sat3_r),
    .seg_idx  (idx3_r),
    .seg      (seg)
  );

  always_comb begin
    // s2
    m_abs  = x1_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x1_r) : SAMPLE_BITS'(x1_r);
    prod_a = PROD_A_BITS'(m_abs) * PROD_A_BITS'(g_r);
    a_wide = A_WIDE'(prod_a) << A_LSH;
    a_nxt  = A_BITS'(a_wide >> A_RSH);

    // s3: scale by 1+asym for non-negative, 1-asym for negative samples
    scale    = neg2_r ? SCALE_BITS'(SCALE_ONE) - SCALE_BITS'(asym_r)
                      : SCALE_BITS'(SCALE_ONE) + SCALE_BITS'(asym_r);
    arg_prod = ARG_PROD_BITS'(a2_r) * ARG_PROD_BITS'(scale);
    arg      = arg_prod[ARG_PROD_BITS-1:16];

    // s5: lo + round(diff * frac)
    ip      = IP_BITS'(seg4_r.diff) * IP_BITS'(fr4_r) + IP_BITS'(IP_ROUND);
    val_nxt = seg4_r.lo + (seg4_r.ge ? ROM_BITS'(ip >> FR_BITS) : '0);

    // s6: round tanh to sample precision, restore sign
    mag_sum = (ROM_BITS + 1)'(val5_r) + (ROM_BITS + 1)'(ROUND_HALF);
    mag     = SAMPLE_BITS'(mag_sum >> ROUND_SH);
    shaped  = neg5_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    wet_s   = $signed({1'b0, wet_w_r});
    dry_s   = $signed({1'b0, dry_w_r});

    // s8
    og_s = $signed({1'b0, ogain_r});

    // s9: round half away from zero, clip to sample range
    vg_neg = vg8_r[VG_BITS-1];
    vm     = vg_neg ? VG_BITS'(-vg8_r) : VG_BITS'(vg8_r);
    vm_sum = (VG_BITS + 1)'(vm) + ((VG_BITS + 1)'(1) << (OUT_SHIFT - 1));
    rq     = RQ_BITS'(vm_sum >> OUT_SHIFT);
    if (vg_neg) begin
      res_mag = (rq > (RQ_BITS'(1) << FRAC_BITS)) ? (SAMPLE_BITS'(1) << FRAC_BITS)
                                                  : SAMPLE_BITS'(rq);
      shaped_out = $signed(-res_mag);
    end else begin
      res_mag = (rq > ((RQ_BITS'(1) << FRAC_BITS) - RQ_BITS'(1)))
              ? ((SAMPLE_BITS'(1) << FRAC_BITS) - SAMPLE_BITS'(1)) : SAMPLE_BITS'(rq);
      shaped_out = $signed(res_mag);
    end
    out_nxt = enable_r ? shaped_out : x8_r;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1_r  <= in_sample_in;
      be1_r <= in_block_end;
    end
    if (en[2]) begin
      a2_r   <= a_nxt;
      neg2_r <= x1_r[SAMPLE_BITS-1];
      x2_r   <= x1_r;
      be2_r  <= be1_r;
    end
    if (en[3]) begin
      sat3_r <= |arg[ARG_BITS-1:SPAN_BIT];
      idx3_r <= arg[SPAN_BIT-1:IDX_LSB];
      fr3_r  <= arg[IDX_LSB-1:FR_LSB];
      neg3_r <= neg2_r;
      x3_r   <= x2_r;
      be3_r  <= be2_r;
    end
    if (en[4]) begin
      seg4_r <= seg;
      fr4_r  <= fr3_r;
      neg4_r <= neg3_r;
      x4_r   <= x3_r;
      be4_r  <= be3_r;
    end
    if (en[5]) begin
      val5_r <= val_nxt;
      neg5_r <= neg4_r;
      x5_r   <= x4_r;
      be5_r  <= be4_r;
    end
    if (en[6]) begin
      p1_6_r <= MIX_BITS'(x5_r) * MIX_BITS'(dry_s);
      p2_6_r <= MIX_BITS'(shaped) * MIX_BITS'(wet_s);
      x6_r   <= x5_r;
      be6_r  <= be5_r;
    end
    if (en[7]) begin
      v7_r  <= V_BITS'(p1_6_r) + V_BITS'(p2_6_r);
      x7_r  <= x6_r;
      be7_r <= be6_r;
    end
    if (en[8]) begin
      vg8_r <= VG_BITS'(v7_r) * VG_BITS'(og_s);
      x8_r  <= x7_r;
      be8_r <= be7_r;
    end
    if (en[9]) begin
      out_sample_r <= out_nxt;
      out_be_r     <= be8_r;
    end
  end

  assign out_sample_out    = out_sample_r;
  assign out_block_end_out = out_be_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // intake only stalls when every stage holds a sample
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("intake stalled with a free stage");

  // samples in flight change only by intake and delivery
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_acc && !out_acc) |=> ($countones(v_r) == $past($countones(v_r))))
    else $error("sample lost or duplicated in pipeline");

  // bypass delivers the raw sample
  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (en[STAGES] && v_r[STAGES-1] && !enable_r) |=> (out_sample_out == $past(x8_r)))
    else $error("bypass sample altered");
`endif

endmodule
